FILE: design/smm_pkg.sv
// ----------------------------------------------------------------------------
// smm_pkg
// Shared widths and limits for the sort / min / max / mode unit.
// ----------------------------------------------------------------------------
package smm_pkg;

    localparam int DEPTH_DEFAULT = 32;
    localparam int VALUE_W       = 16;
    localparam int TOP_W         = 6;
    localparam int TOP_MAX       = 63;

    typedef logic [VALUE_W-1:0] value_t;

endpackage

FILE: design/smm_ram.sv
// ----------------------------------------------------------------------------
// smm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module smm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/sort_min_max_mode_unit.sv
// ----------------------------------------------------------------------------
// sort_min_max_mode_unit
// Loads a set of unsigned words, sorts them and streams them out in ascending
// order with the set's minimum, maximum and highest repeat count.
// ----------------------------------------------------------------------------
// Usage
//   Input: a word (value, final_item) is taken on a clock edge with start high
//   and busy low. Each word is put into its sorted place at once: into an
//   empty store it is written directly, otherwise a compare-and-shift loop
//   runs over the store, one element per cycle.
//   Words beyond DEPTH are dropped; their final_item still closes the set.
//   After the final word three passes run over the store through its single
//   read port: a count pass, a mode marking pass and the output pass,
//   emitting one result per cycle; results and result_strobe are registered.
//   Output: each result is held for one cycle with result_strobe high; the
//   receiver cannot stall, so results are never held back. busy is high in
//   the shift loop and from the final word until the last result is issued.
//   Reset: asynchronous, active low; store contents are not cleared, the fill
//   count and all control state are.
// ----------------------------------------------------------------------------
module sort_min_max_mode_unit #(
    parameter int DEPTH = smm_pkg::DEPTH_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [smm_pkg::VALUE_W-1:0] value,
    input  logic                       final_item,
    output logic                       busy,
    output logic                       result_strobe,
    output logic [smm_pkg::VALUE_W-1:0] sorted_value,
    output logic                       end_of_list,
    output logic [smm_pkg::VALUE_W-1:0] smallest,
    output logic [smm_pkg::VALUE_W-1:0] largest,
    output logic [smm_pkg::TOP_W-1:0]   top_count,
    output logic                       is_mode
);

    import smm_pkg::*;

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_INS   = 4'd1;
    localparam logic [3:0] ST_PUT   = 4'd2;
    localparam logic [3:0] ST_SCAN0 = 4'd3;
    localparam logic [3:0] ST_SCAN  = 4'd4;
    localparam logic [3:0] ST_MARK0 = 4'd5;
    localparam logic [3:0] ST_MARK  = 4'd6;
    localparam logic [3:0] ST_EMIT0 = 4'd7;
    localparam logic [3:0] ST_EMIT  = 4'd8;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [AW-1:0]    b_reg, b_next;
    logic [AW-1:0]    pos_reg, pos_next;
    logic [AW-1:0]    start_reg, start_next;
    logic [CNT_W-1:0] run_reg, run_next;
    logic [CNT_W-1:0] best_reg, best_next;
    logic [DEPTH-1:0] flag_reg, flag_next;
    logic             last_reg, last_next;
    logic             strobe_reg, strobe_next;

    value_t           key_reg, key_next;
    value_t           prev_reg, prev_next;
    value_t           small_reg, small_next;
    value_t           large_reg, large_next;

    value_t           sorted_reg;
    logic             eol_reg;
    value_t           small_out_reg;
    value_t           large_out_reg;
    logic [TOP_W-1:0] top_reg;
    logic             mode_reg;

    logic             we;
    logic [AW-1:0]    waddr;
    value_t           wdata;
    logic [AW-1:0]    raddr;
    value_t           rdata;

    logic             accept;
    logic             same;
    logic             at_last;
    logic [CNT_W-1:0] run_new;
    logic [AW-1:0]    start_new;
    logic [TOP_W-1:0] top_sat;

    smm_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign accept    = start && (state_reg == ST_IDLE);
    assign same      = (pos_reg != '0) && (rdata == prev_reg);
    assign at_last   = (CNT_W'(pos_reg) == (fill_reg - CNT_W'(1)));
    assign run_new   = same ? (run_reg + CNT_W'(1)) : CNT_W'(1);
    assign start_new = same ? start_reg : pos_reg;
    assign top_sat   = (32'(best_reg) > 32'(TOP_MAX)) ? TOP_W'(TOP_MAX) : TOP_W'(best_reg);

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        b_next      = b_reg;
        pos_next    = pos_reg;
        start_next  = start_reg;
        run_next    = run_reg;
        best_next   = best_reg;
        flag_next   = flag_reg;
        last_next   = last_reg;
        strobe_next = 1'b0;
        key_next    = key_reg;
        prev_next   = prev_reg;
        small_next  = small_reg;
        large_next  = large_reg;
        we          = 1'b0;
        waddr       = b_reg;
        wdata       = key_reg;
        raddr       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    key_next  = value;
                    last_next = final_item;
                    if (fill_reg < CNT_W'(DEPTH))
                    begin
                        fill_next = fill_reg + CNT_W'(1);
                        b_next    = AW'(fill_reg);
                        if (fill_reg == '0)
                        begin
                            we    = 1'b1;
                            waddr = '0;
                            wdata = value;
                            if (final_item)
                            begin
                                state_next = ST_SCAN0;
                            end
                        end
                        else
                        begin
                            raddr      = AW'(fill_reg - CNT_W'(1));
                            state_next = ST_INS;
                        end
                    end
                    else if (final_item)
                    begin
                        state_next = ST_SCAN0;
                    end
                end
            end

            // rdata holds store[b-1]
            ST_INS:
            begin
                we = 1'b1;
                if (rdata > key_reg)
                begin
                    waddr  = b_reg;
                    wdata  = rdata;
                    b_next = b_reg - AW'(1);
                    if (b_reg == AW'(1))
                    begin
                        state_next = ST_PUT;
                    end
                    else
                    begin
                        raddr = b_reg - AW'(2);
                    end
                end
                else
                begin
                    waddr      = b_reg;
                    wdata      = key_reg;
                    state_next = last_reg ? ST_SCAN0 : ST_IDLE;
                end
            end

            ST_PUT:
            begin
                we         = 1'b1;
                waddr      = b_reg;
                wdata      = key_reg;
                state_next = last_reg ? ST_SCAN0 : ST_IDLE;
            end

            ST_SCAN0:
            begin
                pos_next   = '0;
                best_next  = CNT_W'(1);
                state_next = ST_SCAN;
            end

            ST_SCAN:
            begin
                raddr     = AW'(pos_reg + AW'(1));
                pos_next  = AW'(pos_reg + AW'(1));
                run_next  = run_new;
                prev_next = rdata;
                if (run_new > best_reg)
                begin
                    best_next = run_new;
                end
                if (pos_reg == '0)
                begin
                    small_next = rdata;
                end
                if (at_last)
                begin
                    large_next = rdata;
                    state_next = ST_MARK0;
                end
            end

            ST_MARK0:
            begin
                pos_next   = '0;
                flag_next  = '0;
                state_next = ST_MARK;
            end

            // mark the first element of every run whose length equals the best
            ST_MARK:
            begin
                raddr      = AW'(pos_reg + AW'(1));
                pos_next   = AW'(pos_reg + AW'(1));
                run_next   = run_new;
                prev_next  = rdata;
                start_next = start_new;
                if (!same && (pos_reg != '0) && (run_reg == best_reg))
                begin
                    flag_next[start_reg] = 1'b1;
                end
                if (at_last)
                begin
                    if (run_new == best_reg)
                    begin
                        flag_next[start_new] = 1'b1;
                    end
                    state_next = ST_EMIT0;
                end
            end

            ST_EMIT0:
            begin
                pos_next   = '0;
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                raddr       = AW'(pos_reg + AW'(1));
                pos_next    = AW'(pos_reg + AW'(1));
                strobe_next = 1'b1;
                if (at_last)
                begin
                    fill_next  = '0;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            b_reg      <= '0;
            pos_reg    <= '0;
            start_reg  <= '0;
            run_reg    <= '0;
            best_reg   <= '0;
            flag_reg   <= '0;
            last_reg   <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            b_reg      <= b_next;
            pos_reg    <= pos_next;
            start_reg  <= start_next;
            run_reg    <= run_next;
            best_reg   <= best_next;
            flag_reg   <= flag_next;
            last_reg   <= last_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        prev_reg  <= prev_next;
        small_reg <= small_next;
        large_reg <= large_next;
        if (state_reg == ST_EMIT)
        begin
            sorted_reg    <= rdata;
            eol_reg       <= at_last;
            small_out_reg <= small_reg;
            large_out_reg <= large_reg;
            top_reg       <= top_sat;
            mode_reg      <= flag_reg[pos_reg];
        end
    end

    assign busy          = (state_reg != ST_IDLE);
    assign result_strobe = strobe_reg;
    assign sorted_value  = sorted_reg;
    assign end_of_list   = eol_reg;
    assign smallest      = small_out_reg;
    assign largest       = large_out_reg;
    assign top_count     = top_reg;
    assign is_mode       = mode_reg;

`ifndef ASSERT_OFF
    a_strobe_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(state_reg == ST_EMIT))
        else $error("result strobe without output pass");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(DEPTH))
        else $error("fill count beyond depth");

    a_ins_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INS) |-> (b_reg != '0) && (CNT_W'(b_reg) < fill_reg))
        else $error("insertion index out of range");

    a_set_closed: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && end_of_list) |-> (fill_reg == '0) && (state_reg != ST_EMIT))
        else $error("store not emptied after last result");

    a_top_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> (top_count != '0))
        else $error("zero top count on a result");
`endif

endmodule
